FILE: sv/fcb_pkg.sv
`timescale 1ns / 1ps
// Package for the frame interval coverage bitmap: sizes, the walker command
// and status structs, and the byte population count. No dependencies.
package fcb_pkg;

    // Largest video length the bitmap can hold, in frames.
    localparam int MAX_FRAMES = 65536;

    // Bitmap organization: one 64-bit word per 64 frames.
    localparam int WORD_W     = 64;
    localparam int BIT_W      = $clog2(WORD_W);
    localparam int WORD_COUNT = (MAX_FRAMES + WORD_W - 1) / WORD_W;
    localparam int ADDR_W     = $clog2(WORD_COUNT);

    // Frame numbers, lengths and the covered count share the 17-bit field width.
    localparam int LEN_W  = 17;
    localparam int WIDX_W = LEN_W - BIT_W;

    // Event counters saturate at all ones.
    localparam int CNT_W = 32;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Width of the population count of one bitmap word.
    localparam int PCNT_W = $clog2(WORD_W + 1);

    // Input function codes.
    localparam logic FUNC_MARK  = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    typedef struct packed {
        logic             go;
        logic             clr;
        logic [LEN_W-1:0] first;
        logic [LEN_W-1:0] last;
    } t_walk_cmd;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic              add_valid;
        logic [PCNT_W-1:0] add_cnt;
    } t_walk_sts;

    // Number of set bits in one byte.
    function automatic logic [3:0] pop8(input logic [7:0] b);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++) begin
            n = n + 4'(b[i]);
        end
        return n;
    endfunction

endpackage

FILE: sv/fcb_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered
// read data. No dependencies.
module fcb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/fcb_walk.sv
`timescale 1ns / 1ps
// Bitmap walker: sweeps the bitmap words of one interval, ORs in the range
// mask and counts fresh bits, or writes zeros over the whole bitmap. Uses fcb_pkg.
module fcb_walk (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  fcb_pkg::t_walk_cmd           i_cmd,
    output fcb_pkg::t_walk_sts           o_sts,
    output logic                         o_rd_en,
    output logic [fcb_pkg::ADDR_W-1:0]   o_rd_addr,
    input  logic [fcb_pkg::WORD_W-1:0]   i_rd_data,
    output logic                         o_wr_en,
    output logic [fcb_pkg::ADDR_W-1:0]   o_wr_addr,
    output logic [fcb_pkg::WORD_W-1:0]   o_wr_data
);

    logic                          r_busy;
    logic                          r_issue;
    logic                          r_clr;
    logic [fcb_pkg::ADDR_W-1:0]    r_addr;
    logic [fcb_pkg::ADDR_W-1:0]    r_w0;
    logic [fcb_pkg::ADDR_W-1:0]    r_w1;
    logic [fcb_pkg::BIT_W-1:0]     r_lo;
    logic [fcb_pkg::BIT_W-1:0]     r_hi;
    logic                          r_p1_valid;
    logic [fcb_pkg::ADDR_W-1:0]    r_p1_addr;
    logic                          r_p1_first;
    logic                          r_p1_last;
    logic                          r_p2_valid;
    logic [fcb_pkg::PCNT_W-1:0]    r_p2_cnt;

    logic [fcb_pkg::BIT_W-1:0]     lo;
    logic [fcb_pkg::BIT_W-1:0]     hi;
    logic [fcb_pkg::WORD_W-1:0]    mask;
    logic [fcb_pkg::WORD_W-1:0]    fresh;
    logic [fcb_pkg::PCNT_W-1:0]    fresh_cnt;
    logic                          done;

    // Range mask of the word in the data stage; inner words are all ones.
    always_comb begin
        lo        = r_p1_first ? r_lo : '0;
        hi        = r_p1_last ? r_hi : fcb_pkg::BIT_W'(fcb_pkg::WORD_W - 1);
        mask      = ({fcb_pkg::WORD_W{1'b1}} << lo)
                  & ({fcb_pkg::WORD_W{1'b1}} >> (fcb_pkg::BIT_W'(fcb_pkg::WORD_W - 1) - hi));
        fresh     = mask & ~i_rd_data;
        fresh_cnt = '0;
        for (int k = 0; k < fcb_pkg::WORD_W / 8; k++) begin
            fresh_cnt = fresh_cnt + fcb_pkg::PCNT_W'(fcb_pkg::pop8(fresh[k*8 +: 8]));
        end
    end

    assign done = r_busy && !r_issue && !r_p1_valid && !r_p2_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_issue    <= 1'b0;
            r_clr      <= 1'b0;
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
        end else begin
            r_p1_valid <= r_issue && !r_clr;
            r_p1_addr  <= r_addr;
            r_p1_first <= (r_addr == r_w0);
            r_p1_last  <= (r_addr == r_w1);
            r_p2_valid <= r_p1_valid;
            r_p2_cnt   <= fresh_cnt;
            if (i_cmd.go) begin
                r_busy  <= 1'b1;
                r_issue <= 1'b1;
                r_clr   <= i_cmd.clr;
                r_lo    <= i_cmd.first[fcb_pkg::BIT_W-1:0];
                r_hi    <= i_cmd.last[fcb_pkg::BIT_W-1:0];
                r_w0    <= fcb_pkg::ADDR_W'(i_cmd.first[fcb_pkg::LEN_W-1:fcb_pkg::BIT_W]);
                if (i_cmd.clr) begin
                    r_addr <= '0;
                    r_w1   <= fcb_pkg::ADDR_W'(fcb_pkg::WORD_COUNT - 1);
                end else begin
                    r_addr <= fcb_pkg::ADDR_W'(i_cmd.first[fcb_pkg::LEN_W-1:fcb_pkg::BIT_W]);
                    r_w1   <= fcb_pkg::ADDR_W'(i_cmd.last[fcb_pkg::LEN_W-1:fcb_pkg::BIT_W]);
                end
            end else if (r_issue) begin
                if (r_addr == r_w1) begin
                    r_issue <= 1'b0;
                end else begin
                    r_addr <= r_addr + 1'b1;
                end
            end else if (done) begin
                r_busy <= 1'b0;
            end
        end
    end

    // A clear sweep writes straight from the address counter; a mark writes
    // back the word that was read in the previous cycle.
    assign o_rd_en   = r_issue && !r_clr;
    assign o_rd_addr = r_addr;
    assign o_wr_en   = r_clr ? r_issue : r_p1_valid;
    assign o_wr_addr = r_clr ? r_addr : r_p1_addr;
    assign o_wr_data = r_clr ? '0 : (i_rd_data | mask);

    assign o_sts.busy      = r_busy;
    assign o_sts.done      = done;
    assign o_sts.add_valid = r_p2_valid;
    assign o_sts.add_cnt   = r_p2_cnt;

    a_go_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.go |-> !r_busy)
        else $error("walker started while busy");

    a_no_raw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p1_valid && r_issue) |-> (r_p1_addr != r_addr))
        else $error("walker read and write hit the same word");

endmodule

FILE: sv/fcb_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle: computes (num << 16) / den
// for num <= den. Uses fcb_pkg.
module fcb_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_go,
    input  logic [fcb_pkg::LEN_W-1:0]  i_num,
    input  logic [fcb_pkg::LEN_W-1:0]  i_den,
    output logic                       o_done,
    output logic [fcb_pkg::LEN_W-1:0]  o_quot
);

    localparam int STEP_W = $clog2(fcb_pkg::LEN_W + 1);

    logic                       r_busy;
    logic                       r_done;
    logic [STEP_W-1:0]          r_step;
    logic [fcb_pkg::LEN_W-1:0]  r_rem;
    logic [fcb_pkg::LEN_W-1:0]  r_quot;
    logic [fcb_pkg::LEN_W-1:0]  r_den;

    logic [fcb_pkg::LEN_W:0]    trial;
    logic                       fits;

    // Shared compare and subtract: the next numerator bit comes out of the
    // top of the quotient register as quotient bits shift in below.
    assign trial = {r_rem, r_quot[fcb_pkg::LEN_W-1]};
    assign fits  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(fcb_pkg::LEN_W);
                r_den  <= i_den;
                r_rem  <= {1'b0, i_num[fcb_pkg::LEN_W-1:1]};
                r_quot <= {i_num[0], {(fcb_pkg::LEN_W-1){1'b0}}};
            end else if (r_busy) begin
                r_rem  <= fits ? fcb_pkg::LEN_W'(trial - {1'b0, r_den})
                               : trial[fcb_pkg::LEN_W-1:0];
                r_quot <= {r_quot[fcb_pkg::LEN_W-2:0], fits};
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (r_den != '0)) |-> (r_rem < r_den))
        else $error("divider remainder out of range");

endmodule

FILE: sv/frame_interval_coverage_bitmap.sv
`timescale 1ns / 1ps
// One transaction at a time; the word walk (one RAM word per cycle) and the
// 17-step divider set the pace. Synchronous active-low reset starts a
// 1024-word clearing pass over the bitmap RAM; the input is first ready once
// that pass is done. Depends on fcb_pkg, fcb_ram, fcb_walk, fcb_div.
module frame_interval_coverage_bitmap (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Configuration write channel: video length in frames.
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [fcb_pkg::LEN_W-1:0]  i_cfg_sequence_length,
    // Input transaction channel.
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_func,
    input  logic [fcb_pkg::LEN_W-1:0]  i_start_frame,
    input  logic [fcb_pkg::LEN_W-1:0]  i_end_frame,
    input  logic                       i_is_root,
    // Result transaction channel.
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [fcb_pkg::LEN_W-1:0]  o_covered_frames,
    output logic [fcb_pkg::CNT_W-1:0]  o_events_all,
    output logic [fcb_pkg::CNT_W-1:0]  o_events_root,
    output logic [fcb_pkg::LEN_W-1:0]  o_coverage_q16
);

    // Sequencer states. WALK is used both for the clearing sweep after reset
    // and for the walk of a transaction; r_boot tells the two apart.
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_WALK     = 3'd1;
    localparam logic [2:0] ST_DIV      = 3'd2;
    localparam logic [2:0] ST_DIV_WAIT = 3'd3;
    localparam logic [2:0] ST_DONE     = 3'd4;

    logic [2:0]                  r_state;
    logic                        r_boot;
    logic [fcb_pkg::LEN_W-1:0]   r_seq_len;
    logic [fcb_pkg::LEN_W-1:0]   r_len;
    logic [fcb_pkg::LEN_W-1:0]   r_covered;
    logic [fcb_pkg::CNT_W-1:0]   r_all;
    logic [fcb_pkg::CNT_W-1:0]   r_root;
    logic                        r_walk_go;
    logic                        r_walk_clr;
    logic [fcb_pkg::LEN_W-1:0]   r_first;
    logic [fcb_pkg::LEN_W-1:0]   r_last;
    logic                        r_div_go;
    logic                        r_out_valid;
    logic [fcb_pkg::LEN_W-1:0]   r_out_covered;
    logic [fcb_pkg::CNT_W-1:0]   r_out_all;
    logic [fcb_pkg::CNT_W-1:0]   r_out_root;
    logic [fcb_pkg::LEN_W-1:0]   r_out_cov;

    logic                        in_accept;
    logic [fcb_pkg::LEN_W-1:0]   len_in;
    logic [fcb_pkg::LEN_W-1:0]   t1;
    logic [fcb_pkg::LEN_W-1:0]   t2;
    logic [fcb_pkg::LEN_W-1:0]   end_m1;
    logic                        in_range;
    logic [fcb_pkg::LEN_W-1:0]   div_num;

    fcb_pkg::t_walk_cmd          walk_cmd;
    fcb_pkg::t_walk_sts          walk_sts;

    logic                        rd_en;
    logic [fcb_pkg::ADDR_W-1:0]  rd_addr;
    logic [fcb_pkg::WORD_W-1:0]  rd_data;
    logic                        wr_en;
    logic [fcb_pkg::ADDR_W-1:0]  wr_addr;
    logic [fcb_pkg::WORD_W-1:0]  wr_data;
    logic                        div_done;
    logic [fcb_pkg::LEN_W-1:0]   div_quot;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_accept   = i_in_valid && o_in_ready;

    // Interval setup for a mark. Frames become 0-based here; a zero start
    // counts as the first frame. A start beyond the video marks nothing, an
    // end before the start (a zero end among them) marks only the start
    // frame, and an end past the video stops at its final frame.
    always_comb begin
        len_in = (32'(r_seq_len) > fcb_pkg::MAX_FRAMES)
               ? fcb_pkg::LEN_W'(fcb_pkg::MAX_FRAMES) : r_seq_len;
        t1       = (i_start_frame == '0) ? '0 : i_start_frame - 1'b1;
        end_m1   = i_end_frame - 1'b1;
        in_range = (t1 < len_in);
        if (i_end_frame == '0) begin
            t2 = t1;
        end else if (end_m1 > len_in - 1'b1) begin
            t2 = len_in - 1'b1;
        end else begin
            t2 = end_m1;
        end
        if (t2 < t1) begin
            t2 = t1;
        end
    end

    // The divider sees the covered count limited to the length, so the
    // coverage never exceeds full scale after the length has been reduced.
    assign div_num = (r_covered < r_len) ? r_covered : r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_len <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_seq_len <= i_cfg_sequence_length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_WALK;
            r_boot      <= 1'b1;
            r_walk_go   <= 1'b1;
            r_walk_clr  <= 1'b1;
            r_div_go    <= 1'b0;
            r_covered   <= '0;
            r_all       <= '0;
            r_root      <= '0;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_walk_go <= 1'b0;
            r_div_go  <= 1'b0;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (walk_sts.add_valid) begin
                r_covered <= r_covered + fcb_pkg::LEN_W'(walk_sts.add_cnt);
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_len   <= len_in;
                        r_first <= t1;
                        r_last  <= t2;
                        if (i_func == fcb_pkg::FUNC_CLEAR) begin
                            r_covered  <= '0;
                            r_all      <= '0;
                            r_root     <= '0;
                            r_walk_go  <= 1'b1;
                            r_walk_clr <= 1'b1;
                            r_state    <= ST_WALK;
                        end else begin
                            if (r_all != fcb_pkg::CNT_MAX) begin
                                r_all <= r_all + 1'b1;
                            end
                            if (i_is_root && (r_root != fcb_pkg::CNT_MAX)) begin
                                r_root <= r_root + 1'b1;
                            end
                            if (in_range) begin
                                r_walk_go  <= 1'b1;
                                r_walk_clr <= 1'b0;
                                r_state    <= ST_WALK;
                            end else begin
                                r_state <= ST_DIV;
                            end
                        end
                    end
                end
                ST_WALK: begin
                    if (walk_sts.done) begin
                        if (r_boot) begin
                            r_boot  <= 1'b0;
                            r_state <= ST_IDLE;
                        end else begin
                            r_state <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    r_div_go <= 1'b1;
                    r_state  <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT: begin
                    if (div_done) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // The result register is reloaded only once the previous
                    // result has been taken.
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid   <= 1'b1;
                        r_out_covered <= r_covered;
                        r_out_all     <= r_all;
                        r_out_root    <= r_root;
                        r_out_cov     <= (r_len == '0) ? '0 : div_quot;
                        r_state       <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign walk_cmd.go    = r_walk_go;
    assign walk_cmd.clr   = r_walk_clr;
    assign walk_cmd.first = r_first;
    assign walk_cmd.last  = r_last;

    fcb_ram #(
        .WIDTH (fcb_pkg::WORD_W),
        .DEPTH (fcb_pkg::WORD_COUNT)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    fcb_walk u_walk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (walk_cmd),
        .o_sts     (walk_sts),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data)
    );

    fcb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_div_go),
        .i_num   (div_num),
        .i_den   (r_len),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_out_valid      = r_out_valid;
    assign o_covered_frames = r_out_covered;
    assign o_events_all     = r_out_all;
    assign o_events_root    = r_out_root;
    assign o_coverage_q16   = r_out_cov;

    a_idle_walker_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !walk_sts.busy)
        else $error("input ready while the walker is still busy");

    a_clear_starts_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (i_func == fcb_pkg::FUNC_CLEAR)) |=> (r_walk_go && r_walk_clr))
        else $error("clear transaction did not start a clearing sweep");

    a_covered_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_covered) <= fcb_pkg::MAX_FRAMES)
        else $error("covered count beyond the bitmap size");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for frame_interval_coverage_bitmap: directed interval
// cases, then random traffic over several video lengths. Depends on fcb_pkg.
module tb;

    // Run length guard: cycles in a row with no transaction on any channel.
    // The longest quiet stretch in a correct run is a bitmap clear or a full
    // 1024-word walk plus a long result stall, or the clearing pass after reset.
    localparam int STALL_LIMIT = 6000;

    localparam logic [fcb_pkg::WORD_W-1:0] WORD_ONES = '1;
    localparam logic [fcb_pkg::LEN_W-1:0]  FIELD_ONES = '1;

    // One result transaction as the block reports it.
    typedef struct packed {
        logic [fcb_pkg::LEN_W-1:0] covered_frames;
        logic [fcb_pkg::CNT_W-1:0] events_all;
        logic [fcb_pkg::CNT_W-1:0] events_root;
        logic [fcb_pkg::LEN_W-1:0] coverage_q16;
    } t_cov_result;

    // Clock and reset.
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // All inputs of the block start at known values.
    logic                      cfg_valid = 1'b0;
    logic [fcb_pkg::LEN_W-1:0] cfg_length = '0;
    logic                      in_valid = 1'b0;
    logic                      in_func = fcb_pkg::FUNC_MARK;
    logic [fcb_pkg::LEN_W-1:0] in_start = '0;
    logic [fcb_pkg::LEN_W-1:0] in_end = '0;
    logic                      in_root = 1'b0;
    logic                      out_ready = 1'b0;

    logic                      o_cfg_ready;
    logic                      o_in_ready;
    logic                      o_out_valid;
    logic [fcb_pkg::LEN_W-1:0] o_covered_frames;
    logic [fcb_pkg::CNT_W-1:0] o_events_all;
    logic [fcb_pkg::CNT_W-1:0] o_events_root;
    logic [fcb_pkg::LEN_W-1:0] o_coverage_q16;

    frame_interval_coverage_bitmap uut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_valid           (cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_sequence_length (cfg_length),
        .i_in_valid            (in_valid),
        .o_in_ready            (o_in_ready),
        .i_func                (in_func),
        .i_start_frame         (in_start),
        .i_end_frame           (in_end),
        .i_is_root             (in_root),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (out_ready),
        .o_covered_frames      (o_covered_frames),
        .o_events_all          (o_events_all),
        .o_events_root         (o_events_root),
        .o_coverage_q16        (o_coverage_q16)
    );

    // Shadow copy of the block's state, kept in step with accepted transactions.
    logic [fcb_pkg::WORD_W-1:0] shadow_marks [fcb_pkg::WORD_COUNT];
    int unsigned                shadow_covered;
    logic [fcb_pkg::CNT_W-1:0]  shadow_events_all;
    logic [fcb_pkg::CNT_W-1:0]  shadow_events_root;
    logic [fcb_pkg::LEN_W-1:0]  shadow_seq_length;

    // Results predicted but not yet seen on the output, oldest first.
    t_cov_result pending_results [$];

    // When set, neither side inserts idle cycles.
    bit burst_mode = 1'b0;

    int err_count;
    int n_items;
    int n_clears;
    int n_results;
    int n_lengths;

    initial begin
        foreach (shadow_marks[i]) shadow_marks[i] = '0;
        shadow_covered     = 0;
        shadow_events_all  = '0;
        shadow_events_root = '0;
        shadow_seq_length  = '0;
    end

    // The block never tracks more frames than the bitmap holds.
    function automatic int unsigned length_in_use();
        return (shadow_seq_length > fcb_pkg::MAX_FRAMES) ? fcb_pkg::MAX_FRAMES
                                                         : int'(shadow_seq_length);
    endfunction

    // Apply one accepted transaction to the shadow state and return the result
    // the block must report for it.
    function automatic t_cov_result apply_coverage_item(
            input logic func,
            input logic [fcb_pkg::LEN_W-1:0] start_f,
            input logic [fcb_pkg::LEN_W-1:0] end_f,
            input logic root);
        int unsigned                len;
        int unsigned                first_f;
        int unsigned                last_f;
        int unsigned                lo;
        int unsigned                hi;
        int unsigned                capped;
        logic [fcb_pkg::WORD_W-1:0] mask;
        longint unsigned            scaled;
        t_cov_result                res;

        len = length_in_use();
        if (func == fcb_pkg::FUNC_CLEAR) begin
            foreach (shadow_marks[i]) shadow_marks[i] = '0;
            shadow_covered     = 0;
            shadow_events_all  = '0;
            shadow_events_root = '0;
        end else begin
            // Frame numbers arrive 1-based; frame zero means the first frame.
            first_f = (start_f == 0) ? 0 : int'(start_f) - 1;
            if (shadow_events_all != fcb_pkg::CNT_MAX) shadow_events_all++;
            if (root && shadow_events_root != fcb_pkg::CNT_MAX) shadow_events_root++;
            // An event that starts beyond the video is counted but marks nothing.
            if (first_f < len) begin
                if (end_f == 0) begin
                    last_f = first_f;
                end else begin
                    last_f = int'(end_f) - 1;
                    if (last_f > len - 1) last_f = len - 1;
                    if (last_f < first_f) last_f = first_f;
                end
                for (int unsigned w = first_f >> fcb_pkg::BIT_W;
                     w <= (last_f >> fcb_pkg::BIT_W); w++) begin
                    lo   = (w == (first_f >> fcb_pkg::BIT_W)) ? (first_f % fcb_pkg::WORD_W)
                                                              : 0;
                    hi   = (w == (last_f >> fcb_pkg::BIT_W)) ? (last_f % fcb_pkg::WORD_W)
                                                             : fcb_pkg::WORD_W - 1;
                    mask = (WORD_ONES << lo) & (WORD_ONES >> (fcb_pkg::WORD_W - 1 - hi));
                    shadow_covered  += $countones(mask & ~shadow_marks[w]);
                    shadow_marks[w] |= mask;
                end
            end
        end

        // Coverage uses the covered count capped at the length, so a length cut
        // after marking still reports at most full coverage.
        res.coverage_q16 = '0;
        if (len != 0) begin
            capped = (shadow_covered < len) ? shadow_covered : len;
            scaled = (longint'(capped) << 16) / len;
            res.coverage_q16 = scaled[fcb_pkg::LEN_W-1:0];
        end
        res.covered_frames = (shadow_covered > FIELD_ONES)
                           ? FIELD_ONES : shadow_covered[fcb_pkg::LEN_W-1:0];
        res.events_all  = shadow_events_all;
        res.events_root = shadow_events_root;
        return res;
    endfunction

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int roll;
        if (burst_mode) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Send one input transaction. Valid stays high across back-to-back items,
    // so it is only lowered when an idle gap is taken.
    task automatic send_item(input logic func,
                             input logic [fcb_pkg::LEN_W-1:0] start_f,
                             input logic [fcb_pkg::LEN_W-1:0] end_f,
                             input logic root);
        int          gap;
        t_cov_result res;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_func  = func;
        in_start = start_f;
        in_end   = end_f;
        in_root  = root;
        in_valid = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        res = apply_coverage_item(func, start_f, end_f, root);
        pending_results.push_back(res);
        n_items++;
        if (func == fcb_pkg::FUNC_CLEAR) n_clears++;
    endtask

    task automatic hold_input_idle();
        @(negedge i_clk);
        in_valid = 1'b0;
    endtask

    // Stop sending and wait until every predicted result has been checked.
    task automatic wait_drained();
        hold_input_idle();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Write the video length. Only called with the block idle.
    task automatic write_length(input logic [fcb_pkg::LEN_W-1:0] value);
        wait_drained();
        @(negedge i_clk);
        cfg_length = value;
        cfg_valid  = 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        shadow_seq_length = value;
        n_lengths++;
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    task automatic check_field(input string name, input longint unsigned expected,
                               input longint unsigned actual);
        if (expected != actual) begin
            $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
            err_count++;
        end
    endtask

    // Result side: random back-pressure driven at the falling edge.
    int ready_hold;
    initial ready_hold = 0;

    always @(negedge i_clk) begin
        if (ready_hold > 0 && !burst_mode) begin
            out_ready  = 1'b0;
            ready_hold = ready_hold - 1;
        end else begin
            out_ready  = 1'b1;
            ready_hold = 0;
            if (!burst_mode && $urandom_range(0, 9) == 0) ready_hold = pick_gap();
        end
    end

    // Every accepted result is compared with the oldest prediction.
    always @(posedge i_clk) begin
        t_cov_result expected_r;
        if (i_rst_n && o_out_valid && out_ready) begin
            n_results++;
            if (pending_results.size() == 0) begin
                $error("result transaction with no prediction waiting");
                err_count++;
            end else begin
                expected_r = pending_results.pop_front();
                check_field("covered_frames", expected_r.covered_frames, o_covered_frames);
                check_field("events_all", expected_r.events_all, o_events_all);
                check_field("events_root", expected_r.events_root, o_events_root);
                check_field("coverage_q16", expected_r.coverage_q16, o_coverage_q16);
            end
        end
    end

    // The run ends if no channel completes a transaction for too long.
    initial begin : stall_watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready) ||
                (cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, pending_results.size());
        $display("== FAIL ==");
        $finish;
    end

    // With the reset length of zero, events are counted but nothing is marked.
    task automatic test_empty_video();
        send_item(fcb_pkg::FUNC_MARK, 17'd5, 17'd9, 1'b1);
        send_item(fcb_pkg::FUNC_MARK, 17'd0, 17'd0, 1'b0);
    endtask

    // How the interval is derived from the start and end frames.
    task automatic test_interval_rules();
        write_length(17'd100);
        send_item(fcb_pkg::FUNC_MARK, 17'd0, 17'd3, 1'b0);     // zero start counts as frame 1
        send_item(fcb_pkg::FUNC_MARK, 17'd10, 17'd0, 1'b1);    // zero end marks only the start
        send_item(fcb_pkg::FUNC_MARK, 17'd20, 17'd15, 1'b0);   // end before start, start only
        send_item(fcb_pkg::FUNC_MARK, 17'd95, 17'd500, 1'b1);  // end clipped to the last frame
        send_item(fcb_pkg::FUNC_MARK, 17'd101, 17'd105, 1'b0); // starts past the video
        send_item(fcb_pkg::FUNC_MARK, 17'd100, 17'd100, 1'b1); // last frame, already marked
        send_item(fcb_pkg::FUNC_MARK, 17'd2, 17'd12, 1'b0);    // overlaps earlier marks
        send_item(fcb_pkg::FUNC_MARK, FIELD_ONES, FIELD_ONES, 1'b1);
        send_item(fcb_pkg::FUNC_CLEAR, FIELD_ONES, FIELD_ONES, 1'b1);
        send_item(fcb_pkg::FUNC_MARK, 17'd1, 17'd100, 1'b0);   // whole video, full coverage
    endtask

    // Lengths at and beyond the bitmap size, and a length cut after marking.
    task automatic test_length_limits();
        write_length(FIELD_ONES);                              // clipped to MAX_FRAMES
        send_item(fcb_pkg::FUNC_MARK, 17'd1, FIELD_ONES, 1'b1);
        send_item(fcb_pkg::FUNC_MARK, 17'd65536, 17'd65536, 1'b0);
        // The covered count now exceeds the length; coverage saturates at full.
        write_length(17'd1);
        send_item(fcb_pkg::FUNC_MARK, 17'd1, 17'd1, 1'b0);
        write_length(17'd65536);
        send_item(fcb_pkg::FUNC_CLEAR, 17'd0, 17'd0, 1'b0);
        send_item(fcb_pkg::FUNC_MARK, 17'd64, 17'd65, 1'b1);   // straddles a word boundary
        send_item(fcb_pkg::FUNC_MARK, 17'd129, 17'd192, 1'b0); // exactly one whole word
        write_length(17'd64);
        send_item(fcb_pkg::FUNC_MARK, 17'd1, 17'd64, 1'b0);
    endtask

    // One random item. Most are short intervals placed around the video, so
    // marks overlap and the start often lands just past the end.
    task automatic send_random_item();
        int unsigned len;
        int unsigned roll;
        int unsigned sub;
        int unsigned s;
        int unsigned e;
        logic        root;
        len  = length_in_use();
        root = 1'($urandom_range(0, 1));
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            send_item(fcb_pkg::FUNC_CLEAR, 17'($urandom), 17'($urandom), root);
        end else if (roll < 10) begin
            send_item(fcb_pkg::FUNC_MARK, 17'($urandom), 17'($urandom), root);
        end else if (roll < 14) begin
            // Wide interval anywhere in the video: long word walks.
            s = $urandom_range(1, (len > 0) ? len : 1);
            e = $urandom_range(s, (len > s) ? len : s);
            send_item(fcb_pkg::FUNC_MARK, 17'(s), 17'(e), root);
        end else begin
            s   = $urandom_range(0, len + 2);
            sub = $urandom_range(0, 9);
            if (sub == 0)
                e = 0;
            else if (sub == 1)
                e = (s > 0) ? $urandom_range(0, s - 1) : 0;
            else if (sub == 2)
                e = len + $urandom_range(0, 50);
            else
                e = s + $urandom_range(0, 150);
            send_item(fcb_pkg::FUNC_MARK, 17'(s), 17'(e), root);
        end
    endtask

    // Random traffic over a series of lengths. The bitmap is not cleared
    // between phases, so shorter lengths also see counts above the length.
    task automatic test_random_phases();
        int unsigned lengths [9];
        lengths = '{200, 1, 1000, 65536, 131071, 0, 64, 70000, 0};
        lengths[5] = $urandom_range(2, 5000);
        for (int p = 0; p < 9; p++) begin
            write_length(17'(lengths[p]));
            burst_mode = (p == 2);
            for (int i = 0; i < 58; i++) begin
                // Now and then the sender pauses until the block has caught up.
                if ($urandom_range(0, 59) == 0) wait_drained();
                send_random_item();
            end
            burst_mode = 1'b0;
        end
    endtask

    initial begin
        err_count = 0;
        n_items   = 0;
        n_clears  = 0;
        n_results = 0;
        n_lengths = 0;

        // Reset is held from the start, then released for good.
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_video();
        test_interval_rules();
        test_length_limits();
        test_random_phases();

        wait_drained();
        // Let any stray extra result show up before the verdict.
        repeat (64) @(posedge i_clk);

        $display("Sent %0d items (%0d clears) over %0d video length settings.",
                 n_items, n_clears, n_lengths);
        $display("Checked %0d results, %0d mismatches.", n_results, err_count);
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
